### src/bcc_pkg.sv
// Shared constants, codes and the arctangent table of the bearing cone contact test.
package bcc_pkg;

    // Configuration port geometry and register codes
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HALF_WIDTH = 2'd0,
        CFG_RANGE      = 2'd1,
        CFG_SPARE2     = 2'd2,
        CFG_SPARE3     = 2'd3
    } cfg_idx_t;

    // Range test: a magnitude of 2^REACH_BITS or more is always out of reach
    localparam int REACH_BITS = 25;

    // CORDIC geometry: words are normalised so the larger magnitude sits at bit 59
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 64;
    localparam int NORM_TOP     = 59;

    // atan(2^-i) in units of 2^-32 circle
    localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // Latency of the sub-pipelines in register stages
    localparam int RANGE_STAGES = 3;
    localparam int NORM_STAGES  = 3;

endpackage

### src/bcc_range.sv
// Three-stage squared distance against squared reach comparison.
module bcc_range #(
    parameter int DW = 33
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic signed [DW-1:0]                  dx,
    input  logic signed [DW-1:0]                  dy,
    input  logic signed [DW-1:0]                  dz,
    input  logic        [bcc_pkg::REACH_BITS-1:0] reach,
    output logic                                  dist_ok
);

    localparam int RB = bcc_pkg::REACH_BITS;
    localparam int MW = (DW > RB + 1) ? DW : RB + 1;

    logic [RB-1:0]   mag_reg [0:2];
    logic [RB-1:0]   reach1_reg;
    logic            big1_reg;
    logic [2*RB-1:0] sq_reg  [0:2];
    logic [2*RB-1:0] rsq_reg;
    logic            big2_reg;
    logic            ok_reg;

    logic [MW-1:0]   m_ext [0:2];
    logic [2:0]      big_v;
    logic [2*RB+1:0] sum;

    function automatic logic [MW-1:0] abs_ext(input logic signed [DW-1:0] v);
        logic [DW-1:0] a;
        a = v[DW-1] ? (~v + 1'b1) : v;
        return MW'(a);
    endfunction

    // Magnitudes; anything with a bit at or above 2^RB is out of reach
    always_comb
    begin
        m_ext[0] = abs_ext(dx);
        m_ext[1] = abs_ext(dy);
        m_ext[2] = abs_ext(dz);
        for (int k = 0; k < 3; k++)
        begin
            big_v[k] = |m_ext[k][MW-1:RB];
        end
        sum = (2*RB+2)'(sq_reg[0]) + (2*RB+2)'(sq_reg[1]) + (2*RB+2)'(sq_reg[2]);
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[k] <= m_ext[k][RB-1:0];
                sq_reg[k]  <= mag_reg[k] * mag_reg[k];
            end
            reach1_reg <= reach;
            big1_reg   <= |big_v;
            rsq_reg    <= reach1_reg * reach1_reg;
            big2_reg   <= big1_reg;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else if (adv)
        begin
            ok_reg <= !big2_reg && (sum <= (2*RB+2)'(rsq_reg));
        end
    end

    assign dist_ok = ok_reg;

endmodule

### src/bcc_cordic.sv
// Normalising front end and thirty-stage CORDIC vectoring pipeline for the bearing.
module bcc_cordic #(
    parameter int DW = 33
) (
    input  logic                 clk,
    input  logic                 adv,
    input  logic signed [DW-1:0] dx,
    input  logic signed [DW-1:0] dy,
    output logic [31:0]          acc,
    output logic                 zero
);

    localparam int CW = bcc_pkg::CW;
    localparam int NS = bcc_pkg::CORDIC_STEPS;
    localparam int NT = bcc_pkg::NORM_TOP;

    logic signed [CW-1:0] xa_reg, ya_reg;
    logic [31:0]          acca_reg;
    logic                 za_reg;
    logic signed [CW-1:0] xb_reg, yb_reg;
    logic [CW-1:0]        mb_reg;
    logic [31:0]          accb_reg;
    logic                 zb_reg;

    logic signed [CW-1:0] x_reg   [0:NS];
    logic signed [CW-1:0] y_reg   [0:NS];
    logic [31:0]          acc_reg [0:NS];
    logic                 z_reg   [0:NS];

    logic signed [CW-1:0] xe, ye;
    logic signed [CW-1:0] xb_n, yb_n, xc_n, yc_n;
    logic [CW-1:0]        mb_n, mc_n, ya_abs;

    // Half-plane fold and coarse normalising shifts (32, 16, 8)
    always_comb
    begin
        xe     = CW'(dy);
        ye     = CW'(dx);
        ya_abs = ya_reg[CW-1] ? (~ya_reg + 1'b1) : ya_reg;
        mb_n   = (xa_reg > ya_abs) ? xa_reg : ya_abs;
        xb_n   = xa_reg;
        yb_n   = ya_reg;
        for (int k = 32; k >= 8; k = k / 2)
        begin
            if ((mb_n >> (NT + 1 - k)) == '0)
            begin
                mb_n = mb_n << k;
                xb_n = xb_n <<< k;
                yb_n = yb_n <<< k;
            end
        end
        // fine shifts (4, 2, 1)
        mc_n = mb_reg;
        xc_n = xb_reg;
        yc_n = yb_reg;
        for (int k = 4; k >= 1; k = k / 2)
        begin
            if ((mc_n >> (NT + 1 - k)) == '0)
            begin
                mc_n = mc_n << k;
                xc_n = xc_n <<< k;
                yc_n = yc_n <<< k;
            end
        end
    end

    // Front stages and micro-rotations
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xa_reg   <= xe[CW-1] ? -xe : xe;
            ya_reg   <= xe[CW-1] ? -ye : ye;
            acca_reg <= xe[CW-1] ? 32'h8000_0000 : 32'h0;
            za_reg   <= (dx == '0) && (dy == '0);

            xb_reg   <= xb_n;
            yb_reg   <= yb_n;
            mb_reg   <= mb_n;
            accb_reg <= acca_reg;
            zb_reg   <= za_reg;

            x_reg[0]   <= xc_n;
            y_reg[0]   <= yc_n;
            acc_reg[0] <= accb_reg;
            z_reg[0]   <= zb_reg;

            for (int i = 0; i < NS; i++)
            begin
                if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] + bcc_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] - bcc_pkg::ATAN_TAB[i];
                end
                z_reg[i+1] <= z_reg[i];
            end
        end
    end

    assign acc  = acc_reg[NS];
    assign zero = z_reg[NS];

endmodule

### src/bearing_cone_contact_test.sv
// Top level of the bearing cone contact test: input stage, pipelines, cone test, output.
//
// Usage: one pair word enters on in_valid while in_stall is low; one in_contact
// word leaves on out_valid, taken when out_stall is low. The pipeline is 35
// register stages deep, and a new word is accepted every cycle while
// in_stall is low. Depth is set by the 30-stage CORDIC bearing pipeline
// plus three normalising stages, the input stage and the output register;
// the range test runs beside it in three stages.
// The whole pipeline advances together; it holds only while a result sits in
// the output register and out_stall is high, and in_stall is raised exactly
// then, so nothing is lost or repeated.
// Reset clears all valid bits and both configuration registers. Configuration
// (cfg_write, cfg_index, cfg_data) takes effect at once and should be written
// while the pipeline is empty: index 0 is the cone half width, index 1 the
// range; other indices are ignored.
module bearing_cone_contact_test #(
    parameter int ANGLE_BITS = 16,
    parameter int POS_BITS   = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [bcc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bcc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               both_valid,
    input  logic [47:0]                        src_sector,
    input  logic [47:0]                        dst_sector,
    input  logic signed [POS_BITS-1:0]         src_x,
    input  logic signed [POS_BITS-1:0]         src_y,
    input  logic signed [POS_BITS-1:0]         src_z,
    input  logic signed [POS_BITS-1:0]         dst_x,
    input  logic signed [POS_BITS-1:0]         dst_y,
    input  logic signed [POS_BITS-1:0]         dst_z,
    input  logic signed [16:0]                 dst_size,
    input  logic [15:0]                        heading,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               in_contact
);

    localparam int DW   = POS_BITS + 1;
    localparam int AB   = ANGLE_BITS;
    localparam int RB   = bcc_pkg::REACH_BITS;
    localparam int LAST = bcc_pkg::NORM_STAGES + bcc_pkg::CORDIC_STEPS;
    localparam int NV   = LAST + 2;
    localparam int RS   = bcc_pkg::RANGE_STAGES;
    localparam logic [AB-1:0] QUARTER = {2'b01, {(AB-2){1'b0}}};
    localparam logic [AB-1:0] HALF    = {1'b1, {(AB-1){1'b0}}};

    logic [15:0]   chw_reg;
    logic [23:0]   range_reg;
    logic [NV-1:0] v_reg;
    logic          adv;

    logic signed [DW-1:0] dx0_reg, dy0_reg, dz0_reg;
    logic [RB-1:0]        reach0_reg;
    logic [AB-1:0]        hd_reg  [0:LAST];
    logic                 ok_reg  [0:LAST];
    logic                 dl_reg  [RS+1:LAST];
    logic                 out_reg;

    logic                 dist_ok;
    logic [31:0]          acc;
    logic                 zero;
    logic [31:0]          hd_ext, rnd;
    logic [RB-1:0]        size_c;
    logic [AB-1:0]        bearing, diff, dev;
    logic                 cone_ok;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chw_reg   <= '0;
            range_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (bcc_pkg::cfg_idx_t'(cfg_index))
                bcc_pkg::CFG_HALF_WIDTH: chw_reg   <= cfg_data[15:0];
                bcc_pkg::CFG_RANGE:      range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: all stages move together unless the output word is held
    assign adv      = !(v_reg[NV-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NV-2:0], in_valid};
        end
    end

    // Input stage: offsets, sector match, clamped reach
    always_comb
    begin
        hd_ext = {16'b0, heading};
        size_c = dst_size[16] ? '0 : RB'(dst_size[15:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx0_reg    <= DW'(dst_x) - DW'(src_x);
            dy0_reg    <= DW'(dst_y) - DW'(src_y);
            dz0_reg    <= DW'(dst_z) - DW'(src_z);
            reach0_reg <= size_c + RB'(range_reg);
            hd_reg[0]  <= hd_ext[AB-1:0];
            ok_reg[0]  <= both_valid && (src_sector == dst_sector);
            for (int k = 1; k <= LAST; k++)
            begin
                hd_reg[k] <= hd_reg[k-1];
                ok_reg[k] <= ok_reg[k-1];
            end
            dl_reg[RS+1] <= dist_ok;
            for (int k = RS + 2; k <= LAST; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
            out_reg <= ok_reg[LAST] && dl_reg[LAST] && cone_ok;
        end
    end

    bcc_range #(.DW(DW)) u_range (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .dx      (dx0_reg),
        .dy      (dy0_reg),
        .dz      (dz0_reg),
        .reach   (reach0_reg),
        .dist_ok (dist_ok)
    );

    bcc_cordic #(.DW(DW)) u_cordic (
        .clk  (clk),
        .adv  (adv),
        .dx   (dx0_reg),
        .dy   (dy0_reg),
        .acc  (acc),
        .zero (zero)
    );

    // Bearing rounding and cone test
    always_comb
    begin
        rnd     = acc + (32'd1 << (31 - AB));
        bearing = zero ? QUARTER : rnd[31 -: AB];
        diff    = bearing - hd_reg[LAST];
        dev     = (diff > HALF) ? (~diff + 1'b1) : diff;
        cone_ok = ({16'b0, chw_reg} >= 32'(HALF)) || (32'(dev) <= {16'b0, chw_reg});
    end

    assign out_valid  = v_reg[NV-1];
    assign in_contact = out_reg;

    // Checks
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    a_hold_propagates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(in_contact)))
        else $error("held result not kept");

    a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_stall && !in_valid) |=> !v_reg[0])
        else $error("valid bit invented at pipeline entry");

endmodule
